### design/cbpb_pkg.sv
package cbpb_pkg;

   // Back-end sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQRT,
      ST_DIV,
      ST_MIX,
      ST_OUT
   } back_state_type;

   // Configuration register indexes.
   localparam logic [2:0] REG_CENTER_X = 3'd0;
   localparam logic [2:0] REG_CENTER_Y = 3'd1;
   localparam logic [2:0] REG_RADIUS   = 3'd2;
   localparam logic [2:0] REG_OPACITY  = 3'd3;
   localparam logic [2:0] REG_PAINT    = 3'd4;

   localparam int unsigned OPACITY_ONE = 65536;

endpackage

### design/cbpb_front.sv
// Front end: takes pixel beats, works out the squared distance and the inside
// test, and pushes a classified entry into a two-deep queue.
module cbpb_front #(
   parameter int COORD_BITS = 12,
   parameter int RADIUS_FRAC_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [COORD_BITS-1:0]         req_pixel_x,
   input  logic [COORD_BITS-1:0]         req_pixel_y,
   input  logic [7:0]                    req_current_value,
   input  logic                          req_last_pixel,
   input  logic signed [15:0]            center_x,
   input  logic signed [15:0]            center_y,
   input  logic [19:0]                   radius_q8,
   input  logic [16:0]                   opacity_q16,
   input  logic                          pop,
   output logic                          q_valid,
   output logic [COORD_BITS-1:0]         q_x,
   output logic [COORD_BITS-1:0]         q_y,
   output logic [7:0]                    q_cur,
   output logic                          q_last,
   output logic                          q_active,
   output logic [34:0]                   q_d2
);
   import cbpb_pkg::*;

   localparam int DW = (COORD_BITS > 16 ? COORD_BITS : 16) + 2;

   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in;
   logic [COORD_BITS-1:0] x_ff [2];
   logic [COORD_BITS-1:0] y_ff [2];
   logic [7:0]  c_ff [2];
   logic [1:0]  l_ff;
   logic [1:0]  a_ff;
   logic [34:0] d_ff [2];

   logic signed [DW-1:0] dx, dy;
   logic [34:0] d2;
   logic [19:0] r;
   logic [39:0] r2;
   logic [34+2*RADIUS_FRAC_BITS:0] d2s;
   logic active, push, wr;

   // Distance is one multiply pair and the inside test one more multiply, done on arrival.
   always_comb begin
      dx = DW'($signed({1'b0, req_pixel_x})) - DW'(center_x);
      dy = DW'($signed({1'b0, req_pixel_y})) - DW'(center_y);
      d2 = 35'(dx * dx) + 35'(dy * dy);
      r = (radius_q8 < 20'(1 << (RADIUS_FRAC_BITS - 1)))
         ? 20'(1 << (RADIUS_FRAC_BITS - 1)) : radius_q8;
      r2 = 40'(r) * 40'(r);
      d2s = (35 + 2 * RADIUS_FRAC_BITS)'(d2) << (2 * RADIUS_FRAC_BITS);
      active = (radius_q8 != '0) && (opacity_q16 != '0)
         && (d2s <= (35 + 2 * RADIUS_FRAC_BITS)'(r2));
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push = req_valid && !req_stall;
   assign q_valid = (cnt_ff != 2'd0);

   // Queue pointers.
   always_comb begin
      cnt_in = cnt_ff + 2'(push) - 2'(pop && q_valid);
      rd_in = rd_ff ^ (pop && q_valid);
      wr = rd_ff ^ cnt_ff[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff <= rd_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         x_ff[wr] <= req_pixel_x;
         y_ff[wr] <= req_pixel_y;
         c_ff[wr] <= req_current_value;
         l_ff[wr] <= req_last_pixel;
         a_ff[wr] <= active;
         d_ff[wr] <= d2;
      end
   end

   assign q_x = x_ff[rd_ff];
   assign q_y = y_ff[rd_ff];
   assign q_cur = c_ff[rd_ff];
   assign q_last = l_ff[rd_ff];
   assign q_active = a_ff[rd_ff];
   assign q_d2 = d_ff[rd_ff];
endmodule

### design/cbpb_back.sv
// Back end: bit-serial square root, restoring divide, mix, and dirty box.
module cbpb_back #(
   parameter int COORD_BITS = 12,
   parameter int RADIUS_FRAC_BITS = 8,
   parameter int BLEND_FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  logic [COORD_BITS-1:0] q_x,
   input  logic [COORD_BITS-1:0] q_y,
   input  logic [7:0]            q_cur,
   input  logic                  q_last,
   input  logic                  q_active,
   input  logic [34:0]           q_d2,
   output logic                  pop,
   input  logic [19:0]           radius_q8,
   input  logic [16:0]           opacity_q16,
   input  logic [7:0]            paint_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_new_value,
   output logic                  rsp_write_enable,
   output logic                  rsp_stroke_changed,
   output logic [COORD_BITS-1:0] rsp_dirty_min_x,
   output logic [COORD_BITS-1:0] rsp_dirty_max_x,
   output logic [COORD_BITS-1:0] rsp_dirty_min_y,
   output logic [COORD_BITS-1:0] rsp_dirty_max_y,
   output logic                  rsp_end_of_stroke
);
   import cbpb_pkg::*;

   // dist = floor(sqrt(d2) * 2^F) exactly equals isqrt(d2 << 2F), the integer
   // root, computed over 18+F result bits.
   localparam int RB = 18 + RADIUS_FRAC_BITS;
   localparam int NB = 2 * RB;
   localparam int NUMB = 37 + BLEND_FRAC_BITS;
   localparam int DENB = 36;
   localparam int SC = $clog2(RB + 1);
   localparam int DC = $clog2(NUMB + 1);
   localparam logic [COORD_BITS-1:0] CMAX = '1;

   back_state_type st_ff, st_in;
   logic [NB-1:0]   rem_n_ff, rem_n_in;   // operand being shifted out
   logic [RB+1:0]   srem_ff, srem_in;
   logic [RB-1:0]   root_ff, root_in;
   logic [SC-1:0]   scnt_ff, scnt_in;
   logic [NUMB-1:0] num_ff, num_in;
   logic [DENB:0]   drem_ff, drem_in;
   logic [NUMB-1:0] quo_ff, quo_in;
   logic [DC-1:0]   dcnt_ff, dcnt_in;
   logic [19:0]     r;
   logic [16:0]     op;
   logic [RB+1:0]   trial;
   logic [DENB:0]   dtry;
   logic [35:0]     den;
   logic [RB-1:0]   dist_q;
   logic [19:0]     diff;
   logic signed [9:0] pdiff;
   logic signed [BLEND_FRAC_BITS+11:0] v;
   logic [BLEND_FRAC_BITS+11:0] rnd;
   logic [7:0]      nv;
   logic            ch;

   logic [7:0] o_val_ff, o_val_in;
   logic o_we_ff, o_we_in, o_ch_ff, o_ch_in, o_eos_ff, o_eos_in, ov_ff, ov_in;
   logic [COORD_BITS-1:0] o_mnx_ff, o_mxx_ff, o_mny_ff, o_mxy_ff;
   logic [COORD_BITS-1:0] o_mnx_in, o_mxx_in, o_mny_in, o_mxy_in;
   logic any_ff, any_in;
   logic [COORD_BITS-1:0] mnx_ff, mxx_ff, mny_ff, mxy_ff;
   logic [COORD_BITS-1:0] mnx_in, mxx_in, mny_in, mxy_in;

   always_comb begin
      r = (radius_q8 < 20'(1 << (RADIUS_FRAC_BITS - 1)))
         ? 20'(1 << (RADIUS_FRAC_BITS - 1)) : radius_q8;
      op = (opacity_q16 > 17'(OPACITY_ONE)) ? 17'(OPACITY_ONE) : opacity_q16;
      den = {r, 16'd0};
      trial = {srem_ff[RB-1:0], rem_n_ff[NB-1 -: 2]} - {root_ff, 2'b01};
      dtry = {drem_ff[DENB-1:0], num_ff[NUMB-1]} - {1'b0, den};
      dist_q = (root_ff > RB'(r)) ? RB'(r) : root_ff;
      diff = r - 20'(dist_q);
      pdiff = $signed({2'b0, paint_value}) - $signed({2'b0, q_cur});
      v = $signed((BLEND_FRAC_BITS + 12)'({q_cur, {BLEND_FRAC_BITS{1'b0}}}))
         + pdiff * $signed({1'b0, quo_ff[BLEND_FRAC_BITS+1:0]});
      if (v < 0) v = '0;
      rnd = (BLEND_FRAC_BITS + 12)'(v + (1 <<< (BLEND_FRAC_BITS - 1)))
         >> BLEND_FRAC_BITS;
      nv = (rnd > 255) ? 8'd255 : rnd[7:0];
      if (!q_active || quo_ff == '0) nv = q_cur;
      ch = (nv != q_cur);
   end

   // Sequencer next state.
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: if (q_valid) st_in = q_active ? ST_SQRT : ST_OUT;
         ST_SQRT: if (scnt_ff == SC'(RB)) st_in = ST_DIV;
         ST_DIV:  if (dcnt_ff == DC'(NUMB - 1)) st_in = ST_MIX;
         ST_MIX:  st_in = ST_OUT;
         ST_OUT:  if (!ov_ff || !rsp_stall) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   // Datapath registers per state.
   always_comb begin
      rem_n_in = rem_n_ff; srem_in = srem_ff; root_in = root_ff; scnt_in = scnt_ff;
      num_in = num_ff; drem_in = drem_ff; quo_in = quo_ff; dcnt_in = dcnt_ff;
      case (st_ff)
         ST_IDLE: begin
            rem_n_in = NB'(q_d2) << (2 * RADIUS_FRAC_BITS);
            srem_in = '0; root_in = '0; scnt_in = '0;
            quo_in = '0;
         end
         ST_SQRT: begin
            num_in = '0; drem_in = '0; dcnt_in = '0;
            if (scnt_ff == SC'(RB)) begin
               // Root complete: form the weight numerator from the clamped distance.
               num_in = NUMB'(37'(op) * 37'(diff)) << BLEND_FRAC_BITS;
            end else begin
               rem_n_in = rem_n_ff << 2;
               scnt_in = scnt_ff + SC'(1);
               if (!trial[RB+1]) begin
                  srem_in = trial;
                  root_in = {root_ff[RB-2:0], 1'b1};
               end else begin
                  srem_in = {srem_ff[RB-1:0], rem_n_ff[NB-1 -: 2]};
                  root_in = {root_ff[RB-2:0], 1'b0};
               end
            end
         end
         ST_DIV: begin
            num_in = num_ff << 1;
            dcnt_in = dcnt_ff + DC'(1);
            if (!dtry[DENB]) begin
               drem_in = dtry;
               quo_in = {quo_ff[NUMB-2:0], 1'b1};
            end else begin
               drem_in = {drem_ff[DENB-1:0], num_ff[NUMB-1]};
               quo_in = {quo_ff[NUMB-2:0], 1'b0};
            end
         end
         default: ;
      endcase
   end

   assign pop = (st_ff == ST_OUT) && (!ov_ff || !rsp_stall);

   // Result register and dirty box update on hand-over.
   always_comb begin
      o_val_in = o_val_ff; o_we_in = o_we_ff; o_ch_in = o_ch_ff; o_eos_in = o_eos_ff;
      o_mnx_in = o_mnx_ff; o_mxx_in = o_mxx_ff; o_mny_in = o_mny_ff; o_mxy_in = o_mxy_ff;
      ov_in = ov_ff && rsp_stall;
      any_in = any_ff; mnx_in = mnx_ff; mxx_in = mxx_ff; mny_in = mny_ff; mxy_in = mxy_ff;
      if (pop) begin
         ov_in = 1'b1;
         if (ch) begin
            any_in = 1'b1;
            if (q_x < mnx_ff) mnx_in = q_x;
            if (q_x > mxx_ff) mxx_in = q_x;
            if (q_y < mny_ff) mny_in = q_y;
            if (q_y > mxy_ff) mxy_in = q_y;
         end
         o_val_in = nv; o_we_in = ch; o_eos_in = q_last;
         o_ch_in = q_last && any_in;
         o_mnx_in = o_ch_in ? mnx_in : '0;
         o_mxx_in = o_ch_in ? mxx_in : '0;
         o_mny_in = o_ch_in ? mny_in : '0;
         o_mxy_in = o_ch_in ? mxy_in : '0;
         if (q_last) begin
            any_in = 1'b0; mnx_in = CMAX; mxx_in = '0; mny_in = CMAX; mxy_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         ov_ff <= 1'b0;
         any_ff <= 1'b0;
         mnx_ff <= CMAX; mxx_ff <= '0; mny_ff <= CMAX; mxy_ff <= '0;
      end else begin
         st_ff <= st_in;
         ov_ff <= ov_in;
         any_ff <= any_in;
         mnx_ff <= mnx_in; mxx_ff <= mxx_in; mny_ff <= mny_in; mxy_ff <= mxy_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_n_ff <= rem_n_in; srem_ff <= srem_in; root_ff <= root_in; scnt_ff <= scnt_in;
      num_ff <= num_in; drem_ff <= drem_in; quo_ff <= quo_in; dcnt_ff <= dcnt_in;
      o_val_ff <= o_val_in; o_we_ff <= o_we_in; o_ch_ff <= o_ch_in; o_eos_ff <= o_eos_in;
      o_mnx_ff <= o_mnx_in; o_mxx_ff <= o_mxx_in; o_mny_ff <= o_mny_in; o_mxy_ff <= o_mxy_in;
   end

   assign rsp_valid = ov_ff;
   assign rsp_new_value = o_val_ff;
   assign rsp_write_enable = o_we_ff;
   assign rsp_stroke_changed = o_ch_ff;
   assign rsp_dirty_min_x = o_mnx_ff;
   assign rsp_dirty_max_x = o_mxx_ff;
   assign rsp_dirty_min_y = o_mny_ff;
   assign rsp_dirty_max_y = o_mxy_ff;
   assign rsp_end_of_stroke = o_eos_ff;
endmodule

### design/circular_brush_pixel_blend.sv
// Circular brush pixel blend.
// Pixel beats enter on the req_ channel (valid/stall) with their column, row,
// stored byte and a last-pixel mark. Each gives one rsp_ beat with the blended
// byte, a write enable, and on the last pixel the stroke's dirty box.
// Brush centre, radius, opacity and paint value are written on the csr_ port
// (valid/ready, always ready) while no pixel is in flight.
// A front end computes the squared distance and inside test on arrival and
// queues up to two pixels; a back end runs a bit-serial square root and a
// restoring divide on one pixel at a time, and takes the next pixel only after
// the last one's result is handed to its result register. A pixel outside, or
// with the stroke disabled, skips the root and the divide.
// The back end holds a result register: when rsp_stall is high the result
// waits there and the queue fills, then req_stall rises.
// Synchronous reset clears control and configuration registers, queue and dirty box; no clearing pass.
module circular_brush_pixel_blend #(
   parameter int COORD_BITS = 12,
   parameter int RADIUS_FRAC_BITS = 8,
   parameter int BLEND_FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [COORD_BITS-1:0] req_pixel_x,
   input  logic [COORD_BITS-1:0] req_pixel_y,
   input  logic [7:0]            req_current_value,
   input  logic                  req_last_pixel,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_new_value,
   output logic                  rsp_write_enable,
   output logic                  rsp_stroke_changed,
   output logic [COORD_BITS-1:0] rsp_dirty_min_x,
   output logic [COORD_BITS-1:0] rsp_dirty_max_x,
   output logic [COORD_BITS-1:0] rsp_dirty_min_y,
   output logic [COORD_BITS-1:0] rsp_dirty_max_y,
   output logic                  rsp_end_of_stroke,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [19:0]           csr_data
);
   import cbpb_pkg::*;

   logic signed [15:0] cx_ff, cy_ff;
   logic [19:0] rad_ff;
   logic [16:0] op_ff;
   logic [7:0]  paint_ff;
   logic q_valid, q_last, q_active, pop;
   logic [COORD_BITS-1:0] q_x, q_y;
   logic [7:0] q_cur;
   logic [34:0] q_d2;

   assign csr_ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= '0; cy_ff <= '0; rad_ff <= '0; op_ff <= '0; paint_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_CENTER_X: cx_ff <= csr_data[15:0];
            REG_CENTER_Y: cy_ff <= csr_data[15:0];
            REG_RADIUS:   rad_ff <= csr_data;
            REG_OPACITY:  op_ff <= csr_data[16:0];
            REG_PAINT:    paint_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   cbpb_front #(.COORD_BITS(COORD_BITS), .RADIUS_FRAC_BITS(RADIUS_FRAC_BITS)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_pixel_x, .req_pixel_y,
      .req_current_value, .req_last_pixel,
      .center_x(cx_ff), .center_y(cy_ff), .radius_q8(rad_ff), .opacity_q16(op_ff),
      .pop, .q_valid, .q_x, .q_y, .q_cur, .q_last, .q_active, .q_d2
   );

   cbpb_back #(.COORD_BITS(COORD_BITS), .RADIUS_FRAC_BITS(RADIUS_FRAC_BITS),
      .BLEND_FRAC_BITS(BLEND_FRAC_BITS)) u_back (
      .clock, .reset, .q_valid, .q_x, .q_y, .q_cur, .q_last, .q_active, .q_d2, .pop,
      .radius_q8(rad_ff), .opacity_q16(op_ff), .paint_value(paint_ff),
      .rsp_valid, .rsp_stall, .rsp_new_value, .rsp_write_enable, .rsp_stroke_changed,
      .rsp_dirty_min_x, .rsp_dirty_max_x, .rsp_dirty_min_y, .rsp_dirty_max_y,
      .rsp_end_of_stroke
   );
endmodule

### design/cbpb_checker.sv
// Port-level checks of the brush blend.
module cbpb_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_new_value,
   input logic       rsp_write_enable,
   input logic       rsp_stroke_changed,
   input logic       rsp_end_of_stroke
);
   // A stalled result beat stays offered.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("result dropped");

   // A stalled value does not change.
   a_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_new_value)) else $error("value moved");

   // Stroke summary only on the last pixel.
   a_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stroke_changed |-> rsp_end_of_stroke) else $error("stray summary");

   // A changed last pixel always reports a change.
   a_change: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_stroke && rsp_write_enable |-> rsp_stroke_changed)
      else $error("change lost");
endmodule

bind circular_brush_pixel_blend cbpb_checker u_cbpb_checker (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_new_value, .rsp_write_enable,
   .rsp_stroke_changed, .rsp_end_of_stroke
);

### tb/circular_brush_pixel_blend_tb.sv
module circular_brush_pixel_blend_tb;
   import cbpb_pkg::*;

   localparam int CYCLE_LIMIT = 1500000;
   localparam int N_PHASES = 12;

   typedef struct {
      logic [11:0] x;
      logic [11:0] y;
      logic [7:0]  cur;
      logic        last;
   } pixel_type;

   typedef struct {
      logic [7:0]  new_value;
      logic        write_enable;
      logic        stroke_changed;
      logic [11:0] min_x;
      logic [11:0] max_x;
      logic [11:0] min_y;
      logic [11:0] max_y;
      logic        end_of_stroke;
   } blend_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [11:0] req_pixel_x = '0;
   logic [11:0] req_pixel_y = '0;
   logic [7:0] req_current_value = '0;
   logic req_last_pixel = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [7:0] rsp_new_value;
   logic rsp_write_enable;
   logic rsp_stroke_changed;
   logic [11:0] rsp_dirty_min_x;
   logic [11:0] rsp_dirty_max_x;
   logic [11:0] rsp_dirty_min_y;
   logic [11:0] rsp_dirty_max_y;
   logic rsp_end_of_stroke;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [19:0] csr_data = '0;

   // Brush settings and dirty-box state as the block should hold them.
   longint brush_cx, brush_cy, brush_radius, brush_opacity, brush_paint;
   logic       box_dirty;
   logic [11:0] box_lo_x, box_hi_x, box_lo_y, box_hi_y;

   pixel_type pending_pixels[$];
   blend_type expected_blends[$];
   pixel_type driven_pixel;
   int     send_idle_pct = 0;
   int     recv_idle_pct = 0;
   int     hold_cycles = 0;
   bit     hold_request = 0;
   int     errors = 0;
   int     cycles = 0;

   circular_brush_pixel_blend u_dut (.*);

   always #5 clock = ~clock;

   // Largest root whose square does not exceed n.
   function automatic longint floor_sqrt(longint n);
      longint lo, hi, mid;
      lo = 0;
      hi = 64'd1 << 25;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         if (mid * mid <= n) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   // Blended byte and dirty-box summary for one pixel; advances the box state.
   function automatic blend_type blend_pixel(pixel_type p);
      blend_type res;
      longint r, op, dx, dy, d2s, radial, weight, mix;
      logic [7:0] next;
      next = p.cur;
      if (brush_radius != 0 && brush_opacity != 0) begin
         r = (brush_radius < 128) ? 128 : brush_radius;
         op = (brush_opacity > OPACITY_ONE) ? OPACITY_ONE : brush_opacity;
         dx = longint'(p.x) - brush_cx;
         dy = longint'(p.y) - brush_cy;
         d2s = (dx * dx + dy * dy) << 16;
         if (d2s <= r * r) begin
            radial = floor_sqrt(d2s);
            if (radial > r) radial = r;
            weight = ((op * (r - radial)) << 16) / (r << 16);
            if (weight != 0) begin
               mix = (longint'(p.cur) << 16) + (brush_paint - longint'(p.cur)) * weight;
               if (mix < 0) mix = 0;
               mix = (mix + 32768) >>> 16;
               next = (mix > 255) ? 8'd255 : mix[7:0];
            end
         end
      end
      res = '{default: '0};
      res.new_value = next;
      res.write_enable = (next != p.cur);
      res.end_of_stroke = p.last;
      if (res.write_enable) begin
         box_dirty = 1'b1;
         if (p.x < box_lo_x) box_lo_x = p.x;
         if (p.x > box_hi_x) box_hi_x = p.x;
         if (p.y < box_lo_y) box_lo_y = p.y;
         if (p.y > box_hi_y) box_hi_y = p.y;
      end
      if (p.last) begin
         if (box_dirty) begin
            res.stroke_changed = 1'b1;
            res.min_x = box_lo_x;
            res.max_x = box_hi_x;
            res.min_y = box_lo_y;
            res.max_y = box_hi_y;
         end
         box_dirty = 1'b0;
         box_lo_x = '1;
         box_hi_x = '0;
         box_lo_y = '1;
         box_hi_y = '0;
      end
      return res;
   endfunction

   // Cycle count and timeout.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("circular_brush_pixel_blend_tb: done, errors");
         $finish;
      end
   end

   // Pixel driver: a new beat is offered once the previous one is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) expected_blends.push_back(blend_pixel(driven_pixel));
         if (!req_valid || !req_stall) begin
            if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               driven_pixel = pending_pixels.pop_front();
               req_valid <= 1'b1;
               req_pixel_x <= driven_pixel.x;
               req_pixel_y <= driven_pixel.y;
               req_current_value <= driven_pixel.cur;
               req_last_pixel <= driven_pixel.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor with random stalls and the occasional long hold-off.
   always @(posedge clock) begin
      blend_type exp_b;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_blends.size() == 0) begin
            $error("unexpected result beat, new_value %0d", rsp_new_value);
            errors++;
         end else begin
            exp_b = expected_blends.pop_front();
            if (rsp_new_value !== exp_b.new_value) begin
               $error("new_value: expected %0d, got %0d", exp_b.new_value, rsp_new_value);
               errors++;
            end
            if (rsp_write_enable !== exp_b.write_enable) begin
               $error("write_enable: expected %0d, got %0d",
                      exp_b.write_enable, rsp_write_enable);
               errors++;
            end
            if (rsp_stroke_changed !== exp_b.stroke_changed) begin
               $error("stroke_changed: expected %0d, got %0d",
                      exp_b.stroke_changed, rsp_stroke_changed);
               errors++;
            end
            if (rsp_dirty_min_x !== exp_b.min_x) begin
               $error("dirty_min_x: expected %0d, got %0d", exp_b.min_x, rsp_dirty_min_x);
               errors++;
            end
            if (rsp_dirty_max_x !== exp_b.max_x) begin
               $error("dirty_max_x: expected %0d, got %0d", exp_b.max_x, rsp_dirty_max_x);
               errors++;
            end
            if (rsp_dirty_min_y !== exp_b.min_y) begin
               $error("dirty_min_y: expected %0d, got %0d", exp_b.min_y, rsp_dirty_min_y);
               errors++;
            end
            if (rsp_dirty_max_y !== exp_b.max_y) begin
               $error("dirty_max_y: expected %0d, got %0d", exp_b.max_y, rsp_dirty_max_y);
               errors++;
            end
            if (rsp_end_of_stroke !== exp_b.end_of_stroke) begin
               $error("end_of_stroke: expected %0d, got %0d",
                      exp_b.end_of_stroke, rsp_end_of_stroke);
               errors++;
            end
         end
      end
      if (hold_request) begin
         hold_request = 0;
         hold_cycles = 600;
      end
      if (hold_cycles > 0) begin
         hold_cycles = hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // One register write on the configuration port, mirrored into the brush settings.
   task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_CENTER_X: brush_cx = longint'($signed(val[15:0]));
         REG_CENTER_Y: brush_cy = longint'($signed(val[15:0]));
         REG_RADIUS:   brush_radius = val;
         REG_OPACITY:  brush_opacity = val[16:0];
         REG_PAINT:    brush_paint = val[7:0];
         default: ;
      endcase
   endtask

   task automatic set_brush(input int cx, input int cy, input int rad, input int op,
                            input int paint);
      write_reg(REG_CENTER_X, 20'(cx & 16'hFFFF));
      write_reg(REG_CENTER_Y, 20'(cy & 16'hFFFF));
      write_reg(REG_RADIUS, 20'(rad));
      write_reg(REG_OPACITY, 20'(op));
      write_reg(REG_PAINT, 20'(paint));
   endtask

   task automatic add_pixel(input int x, input int y, input int cur, input bit last);
      pixel_type p;
      p.x = 12'(x);
      p.y = 12'(y);
      p.cur = 8'(cur);
      p.last = last;
      pending_pixels.push_back(p);
   endtask

   // Block until every queued pixel has been taken and every result checked.
   task automatic drain();
      do @(negedge clock);
      while (pending_pixels.size() != 0 || req_valid || expected_blends.size() != 0);
      repeat (5) @(negedge clock);
   endtask

   // A stroke: mostly pixels scattered over the brush's box, some stray noise.
   task automatic add_stroke(input int n);
      int span, x, y;
      span = (brush_radius >> 8) + 2;
      if (span > 40) span = 40;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 85) begin
            x = int'(brush_cx) + $urandom_range(2 * span) - span;
            y = int'(brush_cy) + $urandom_range(2 * span) - span;
            x = (x < 0) ? 0 : (x > 4095) ? 4095 : x;
            y = (y < 0) ? 0 : (y > 4095) ? 4095 : y;
            add_pixel(x, y, $urandom_range(255), i == n - 1);
         end else begin
            add_pixel($urandom_range(4095), $urandom_range(4095), $urandom_range(255),
                      (i == n - 1) || ($urandom_range(7) == 0));
         end
      end
   endtask

   initial begin
      int rad, op, cx, cy;
      brush_cx = 0;
      brush_cy = 0;
      brush_radius = 0;
      brush_opacity = 0;
      brush_paint = 0;
      box_dirty = 1'b0;
      box_lo_x = '1;
      box_hi_x = '0;
      box_lo_y = '1;
      box_hi_y = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: centre, rim, outside and corner pixels, full opacity.
      set_brush(100, 100, 2560, 65536, 255);
      add_pixel(100, 100, 0, 0);
      add_pixel(110, 100, 0, 0);
      add_pixel(105, 100, 0, 0);
      add_pixel(100, 107, 255, 0);
      add_pixel(0, 0, 0, 0);
      add_pixel(4095, 4095, 255, 1);
      drain();
      // Opacity above one, tiny radius raised to half a pixel, paint zero.
      set_brush(100, 100, 1, 131071, 0);
      add_pixel(100, 100, 255, 0);
      add_pixel(101, 100, 255, 0);
      add_pixel(100, 100, 0, 1);
      drain();
      // Zero radius disables the stroke; last pixel reports no change.
      set_brush(2000, 2000, 0, 65536, 200);
      add_pixel(2000, 2000, 17, 1);
      drain();
      // Zero opacity with the largest radius and a far-off centre.
      set_brush(-32768, 32767, 1048575, 0, 128);
      add_pixel(0, 4095, 128, 1);
      drain();
      // Largest radius, centre inside: the whole texture is under the brush.
      set_brush(2048, 2048, 1048575, 65536, 255);
      add_pixel(0, 0, 0, 0);
      add_pixel(4095, 0, 3, 0);
      add_pixel(2048, 2048, 254, 0);
      add_pixel(4095, 4095, 255, 1);
      drain();
      set_brush(32767, -32768, 1048575, 40000, 1);
      add_pixel(4095, 0, 250, 0);
      add_pixel(2730, 1365, 200, 1);
      drain();

      // Random strokes: idling pattern moves through the three modes.
      for (int ph = 0; ph < N_PHASES; ph++) begin
         case (ph * 3 / N_PHASES)
            0: begin send_idle_pct = 13; recv_idle_pct = 67; end
            1: begin send_idle_pct = 67; recv_idle_pct = 13; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         case ($urandom_range(9))
            0: rad = 0;
            1: rad = $urandom_range(1, 127);
            2: rad = 1048575;
            default: rad = $urandom_range(128, 24 * 256);
         endcase
         case ($urandom_range(7))
            0: op = 0;
            1: op = 65536;
            2: op = $urandom_range(65537, 131071);
            default: op = $urandom_range(1, 65536);
         endcase
         if ($urandom_range(5) == 0) begin
            cx = $urandom_range(65535) - 32768;
            cy = $urandom_range(65535) - 32768;
         end else begin
            cx = $urandom_range(4095);
            cy = $urandom_range(4095);
         end
         set_brush(cx, cy, rad, op, $urandom_range(255));
         if (ph == 1) hold_request = 1;
         add_stroke(25);
         if (ph == 2) drain();
         add_stroke(25);
         drain();
      end

      if (errors == 0) $display("circular_brush_pixel_blend_tb: done, clean");
      else $display("circular_brush_pixel_blend_tb: done, errors");
      $finish;
   end

endmodule

### sim.f
design/cbpb_pkg.sv
design/cbpb_front.sv
design/cbpb_back.sv
design/circular_brush_pixel_blend.sv
design/cbpb_checker.sv
tb/circular_brush_pixel_blend_tb.sv
